[src/sird_pkg.sv]
package sird_pkg;

  // Input width and symbol table size
  localparam int VALUE_BITS  = 32;
  localparam int MAX_SYMBOLS = 16;

  // Configuration register widths
  localparam int RADIX_W = 5;
  localparam int SYM_W   = 64;
  localparam int CFG_W   = 64;
  localparam int CFG_IDX_W = 2;
  localparam int CHAR_W  = 8;

  // Full symbol table (low and high words together)
  localparam int TABLE_BYTES = (2 * SYM_W) / CHAR_W;

  // Digit and divider geometry
  localparam int DIG_W      = $clog2(MAX_SYMBOLS);
  localparam int STEP_BITS  = 8;
  localparam int CHUNKS     = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int MAG_W      = CHUNKS * STEP_BITS;
  localparam int CHUNK_W    = $clog2(CHUNKS + 1);
  localparam int MAX_DIGITS = VALUE_BITS;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIX    = 2'd0,
    REG_SYM_LOW  = 2'd1,
    REG_SYM_HIGH = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_SIGN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

endpackage

[src/signed_integer_to_radix_digits_core.sv]
// Flow: after accept, the shared divider works out the digits least significant first; then a '-'
//   for a negative value and one character per digit leave through the output register.
// Busy: a new value is taken only while idle, and busy drops as the last character goes out.
// Reset: rst_n low synchronously clears the sequencer, the strobe and all configuration registers
//   (radix 0, so no characters come out until configured); the receiver cannot stall the output.
module signed_integer_to_radix_digits_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [31:0]              in_value,
  output logic                            out_valid,
  output logic [sird_pkg::CHAR_W-1:0]     out_char,
  output logic                            out_is_last,
  input  logic                            cfg_we,
  input  logic [sird_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sird_pkg::CFG_W-1:0]      cfg_data
);
  import sird_pkg::*;

  // Configuration registers
  logic [RADIX_W-1:0] radix_r;
  logic [SYM_W-1:0]   sym_low_r;
  logic [SYM_W-1:0]   sym_high_r;

  // Sequencer and datapath
  state_t             state_r, state_nxt;
  logic [MAG_W-1:0]   work_r, work_nxt;
  logic [DIG_W-1:0]   rem_r, rem_nxt;
  logic [CHUNK_W-1:0] chunk_r, chunk_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               neg_r, neg_nxt;
  logic [DIG_W-1:0]   stack_r   [MAX_DIGITS];
  logic [DIG_W-1:0]   stack_nxt [MAX_DIGITS];

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;

  logic [2*SYM_W-1:0] sym_tab;
  logic               sym_ok;
  logic               in_accept;

  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag;

  // Divider step results
  logic [STEP_BITS-1:0] qbits;
  logic [DIG_W-1:0]     step_rem;
  logic [MAG_W-1:0]     work_shifted;

  assign sym_tab   = {sym_high_r, sym_low_r};
  assign busy      = (state_r != ST_IDLE);
  assign in_accept = start && !busy;

  // Symbol set check: range of the radix, forbidden bytes, and pairwise
  // uniqueness over the used part of the table. Config must only change while idle; the block does not enforce it.
  always_comb begin
    logic bad;
    logic [CHAR_W-1:0] ci;
    bad = (radix_r < RADIX_W'(2)) || (radix_r > RADIX_W'(MAX_SYMBOLS));
    for (int i = 0; i < TABLE_BYTES; i++) begin
      ci = sym_tab[i*CHAR_W +: CHAR_W];
      if (RADIX_W'(i) < radix_r) begin
        if (ci == '0 || ci == CH_MINUS || ci == CH_PLUS) begin
          bad = 1'b1;
        end
        for (int j = i + 1; j < TABLE_BYTES; j++) begin
          if (RADIX_W'(j) < radix_r && sym_tab[j*CHAR_W +: CHAR_W] == ci) begin
            bad = 1'b1;
          end
        end
      end
    end
    sym_ok = !bad;
  end

  // Magnitude in unsigned arithmetic; the most negative value maps to 2^(VALUE_BITS-1)
  assign raw = in_value[VALUE_BITS-1:0];
  assign mag = raw[VALUE_BITS-1] ? VALUE_BITS'(~raw + VALUE_BITS'(1)) : raw;

  // Shared divider: STEP_BITS restoring steps per cycle on the top bits of work_r.
  // Quotient bits shift in at the bottom as dividend bits leave the top.
  always_comb begin
    logic [RADIX_W-1:0] t;
    logic [DIG_W-1:0]   r;
    r     = rem_r;
    qbits = '0;
    for (int k = 0; k < STEP_BITS; k++) begin
      t = {r, work_r[MAG_W-1-k]};
      if (t >= radix_r) begin
        qbits[STEP_BITS-1-k] = 1'b1;
        r = DIG_W'(t - radix_r);
      end else begin
        r = DIG_W'(t);
      end
    end
    step_rem     = r;
    work_shifted = (work_r << STEP_BITS) | MAG_W'(qbits);
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    work_nxt      = work_r;
    rem_nxt       = rem_r;
    chunk_nxt     = chunk_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    stack_nxt     = stack_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = 1'b0;

    case (state_r)
      ST_IDLE: begin
        // Drop the transaction silently when the symbol set is invalid
        if (in_accept && sym_ok) begin
          work_nxt  = MAG_W'(mag);
          neg_nxt   = raw[VALUE_BITS-1];
          rem_nxt   = '0;
          chunk_nxt = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end

      ST_DIV: begin
        work_nxt  = work_shifted;
        rem_nxt   = step_rem;
        chunk_nxt = chunk_r + CHUNK_W'(1);
        if (chunk_r == CHUNK_W'(CHUNKS - 1)) begin
          // Digit done: push the remainder, restart on the quotient
          stack_nxt[0] = step_rem;
          for (int i = 1; i < MAX_DIGITS; i++) begin
            stack_nxt[i] = stack_r[i-1];
          end
          cnt_nxt   = cnt_r + CNT_W'(1);
          rem_nxt   = '0;
          chunk_nxt = '0;
          if (work_shifted == '0) begin
            state_nxt = neg_r ? ST_SIGN : ST_EMIT;
          end
        end
      end

      ST_SIGN: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = CH_MINUS;
        out_last_nxt  = 1'b0;
        state_nxt     = ST_EMIT;
      end

      ST_EMIT: begin
        // Pop the most significant digit from the top of the stack
        out_valid_nxt = 1'b1;
        out_char_nxt  = sym_tab[stack_r[0]*CHAR_W +: CHAR_W];
        out_last_nxt  = (cnt_r == CNT_W'(1));
        for (int i = 0; i < MAX_DIGITS - 1; i++) begin
          stack_nxt[i] = stack_r[i+1];
        end
        stack_nxt[MAX_DIGITS-1] = '0;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // Configuration registers; writes to unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r    <= '0;
      sym_low_r  <= '0;
      sym_high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIX:    radix_r    <= cfg_data[RADIX_W-1:0];
        REG_SYM_LOW:  sym_low_r  <= cfg_data[SYM_W-1:0];
        REG_SYM_HIGH: sym_high_r <= cfg_data[SYM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    work_r     <= work_nxt;
    rem_r      <= rem_nxt;
    chunk_r    <= chunk_nxt;
    neg_r      <= neg_nxt;
    stack_r    <= stack_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_char    = out_char_r;
  assign out_is_last = out_last_r;

  // A character only follows a sign or emit cycle
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_SIGN || state_r == ST_EMIT))
    else $error("character strobe without emit cycle");

  // Last flag only rides on a strobe
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_is_last |-> out_valid)
    else $error("last flag without strobe");

  // A transaction with an invalid symbol set leaves the block idle
  a_invalid_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !sym_ok) |=> !busy)
    else $error("invalid symbol set started a conversion");

  // Digit count never exceeds the stack depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_DIGITS))
    else $error("digit stack overflow");

  // Emission ends with the last flag as the sequencer goes idle
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && state_nxt == ST_IDLE) |=> (out_valid && out_is_last))
    else $error("run ended without last flag");

endmodule

[tb/sv/tb_signed_integer_to_radix_digits_core.sv]
`timescale 1ns / 100ps

module tb_signed_integer_to_radix_digits_core;
  import sird_pkg::*;

  // Index past the last register: a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Longest run is 33 characters: -2^31 in base two.
  localparam int DRAIN_CYCLES  = 200;
  localparam int IDLE_LIMIT    = 4000;
  localparam int PRESSURE_AT   = 60;
  localparam int RANDOM_BASES  = 13;
  localparam int VALUES_PER_OK = 31;
  localparam int VALUES_PER_NG = 8;

  // Decimal and hexadecimal symbol tables, symbol 0 in the lowest byte.
  localparam logic [127:0] DEC_TABLE = {64'h0000_0000_0000_3938, 64'h3736_3534_3332_3130};
  localparam logic [127:0] HEX_TABLE = {64'h4645_4443_4241_3938, 64'h3736_3534_3332_3130};
  // Binary table: unused bytes hold zero, '+' and '-', which must not matter.
  localparam logic [127:0] BIN_TABLE = {64'h2B2D_002B_2D00_2B2D, 64'h2B2D_002B_2D00_3130};

  typedef enum int {SPOIL_PLUS, SPOIL_MINUS, SPOIL_ZERO, SPOIL_DUP} spoil_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } glyph_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [31:0]          in_value = '0;
  logic                 out_valid;
  logic [CHAR_W-1:0]    out_char;
  logic                 out_is_last;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Shadow copy of the configuration registers, updated at the write edge.
  logic [RADIX_W-1:0]   radix_m;
  logic [SYM_W-1:0]     sym_lo_m;
  logic [SYM_W-1:0]     sym_hi_m;

  logic [31:0] pending_values[$];
  glyph_t      glyph_q[$];

  bit took_item = 1'b0;
  bit drain_hold = 1'b0;
  bit calm_tail = 1'b0;
  bit gap_after_busy = 1'b0;
  int gap_left = 0;
  int items_queued = 0;
  int values_taken = 0;
  int values_silent = 0;
  int glyphs_checked = 0;
  int bases_loaded = 0;
  int error_count = 0;
  int quiet_cycles = 0;

  signed_integer_to_radix_digits_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_char   (out_char),
    .out_is_last(out_is_last),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A symbol set is usable when 2..MAX_SYMBOLS symbols are in use and none of
  // them is a zero byte, a sign character, or a repeat of another used symbol.
  function automatic bit base_is_valid();
    logic [127:0]      tbl;
    logic [CHAR_W-1:0] c;
    bit                ok;
    tbl = {sym_hi_m, sym_lo_m};
    ok = (radix_m >= 2) && (radix_m <= MAX_SYMBOLS);
    if (ok) begin
      for (int i = 0; i < int'(radix_m); i++) begin
        c = tbl[8*i +: 8];
        if (c == 8'h00 || c == CH_MINUS || c == CH_PLUS) ok = 1'b0;
        for (int j = 0; j < i; j++)
          if (tbl[8*j +: 8] == c) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // Queue the characters one value turns into: sign first, then the digits
  // most significant first, with the last one flagged.
  function automatic void predict_glyphs(input logic [31:0] v);
    logic [127:0] tbl;
    logic [31:0]  mag;
    logic [31:0]  base;
    int           digs[$];
    glyph_t       g;
    if (!base_is_valid()) begin
      values_silent++;
      return;
    end
    tbl = {sym_hi_m, sym_lo_m};
    base = 32'(radix_m);
    // Two's complement negate in 32 bits already gives 2^31 for the most
    // negative value, read as unsigned.
    mag = v[31] ? (~v + 32'd1) : v;
    do begin
      digs.push_front(int'(mag % base));
      mag = mag / base;
    end while (mag != 0);
    if (v[31]) begin
      g.ch = CH_MINUS;
      g.last = 1'b0;
      glyph_q.push_back(g);
    end
    foreach (digs[k]) begin
      g.ch = tbl[8*digs[k] +: 8];
      g.last = (k == digs.size() - 1);
      glyph_q.push_back(g);
    end
  endfunction

  // Fill n used symbols with distinct legal bytes; the unused ones get anything.
  function automatic logic [127:0] random_table(input int n);
    logic [127:0]      tbl;
    logic [CHAR_W-1:0] c;
    bit                fresh;
    tbl = '0;
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if (i < n) begin
        do begin
          c = 8'($urandom_range(1, 255));
          fresh = (c != CH_PLUS) && (c != CH_MINUS);
          for (int j = 0; j < i; j++)
            if (tbl[8*j +: 8] == c) fresh = 1'b0;
        end while (!fresh);
      end else begin
        c = 8'($urandom);
      end
      tbl[8*i +: 8] = c;
    end
    return tbl;
  endfunction

  // Break one used symbol so that the whole set is rejected.
  function automatic logic [127:0] spoil_table(input logic [127:0] tbl, input int pos,
                                               input spoil_t kind);
    logic [127:0] t;
    t = tbl;
    case (kind)
      SPOIL_PLUS:  t[8*pos +: 8] = CH_PLUS;
      SPOIL_MINUS: t[8*pos +: 8] = CH_MINUS;
      SPOIL_ZERO:  t[8*pos +: 8] = 8'h00;
      default:     t[8*pos +: 8] = t[7:0];
    endcase
    return t;
  endfunction

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      5: v = 32'($urandom_range(0, 40));
      6: begin
        case ($urandom_range(0, 4))
          0: v = 32'h0000_0000;
          1: v = 32'h0000_0001;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'h7FFF_FFFF;
          default: v = 32'h8000_0000;
        endcase
      end
      7: v = 32'd1 << $urandom_range(0, 31);
      8, 9: v = $urandom >> $urandom_range(0, 31);
      default: v = $urandom;
    endcase
    // Flip the sign of the shaped values half of the time.
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  task automatic queue_value(input logic [31:0] v);
    pending_values.push_back(v);
    items_queued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Wait for every value to be taken and every character to arrive, then let
  // the core finish any run that produces nothing.
  task automatic settle_core();
    do @(negedge clk);
    while (values_taken != items_queued || glyph_q.size() != 0 || busy);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic load_base(input logic [CFG_W-1:0] radix_word, input logic [127:0] tbl);
    settle_core();
    write_reg(REG_RADIX, radix_word);
    write_reg(REG_SYM_LOW, tbl[63:0]);
    write_reg(REG_SYM_HIGH, tbl[127:64]);
    bases_loaded++;
    // Hand new values over away from the driver's edge.
    @(posedge clk);
  endtask

  // Monitor: check characters, track register writes, predict on each
  // accepted transaction, and watch for a stall.
  always @(posedge clk) begin
    took_item = 1'b0;
    if (!rst_n) begin
      radix_m  = '0;
      sym_lo_m = '0;
      sym_hi_m = '0;
    end else begin
      if (out_valid) begin
        if (glyph_q.size() == 0) begin
          $display("%0t: unexpected character 0x%02h last=%0b", $time, out_char, out_is_last);
          error_count++;
        end else begin
          glyph_t g;
          g = glyph_q.pop_front();
          glyphs_checked++;
          if (out_char !== g.ch) begin
            $display("%0t: char expected 0x%02h actual 0x%02h", $time, g.ch, out_char);
            error_count++;
          end
          if (out_is_last !== g.last) begin
            $display("%0t: last flag expected %0b actual %0b", $time, g.last, out_is_last);
            error_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_RADIX:    radix_m  = cfg_data[RADIX_W-1:0];
          REG_SYM_LOW:  sym_lo_m = cfg_data;
          REG_SYM_HIGH: sym_hi_m = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        took_item = 1'b1;
        values_taken++;
        predict_glyphs(in_value);
      end
      if (out_valid || took_item) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Driver: present the next value on the falling edge and hold it until the
  // core takes it. Between values, insert a random gap, either counted
  // straight away (so start rises in the middle of a run) or only over idle
  // cycles (so the core sits idle), and now and then drain all results.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !took_item) begin
      // hold the transaction until busy drops
    end else begin
      if (took_item && !calm_tail) begin
        if (values_taken == PRESSURE_AT || $urandom_range(0, 59) == 0) drain_hold = 1'b1;
        if ($urandom_range(0, 2) == 0) begin
          gap_left = $urandom_range(1, 10);
          gap_after_busy = ($urandom_range(0, 1) == 1);
        end
      end
      if (drain_hold && glyph_q.size() == 0) drain_hold = 1'b0;
      if (drain_hold || gap_left > 0 || pending_values.size() == 0) begin
        start <= 1'b0;
        if (gap_left > 0 && !(gap_after_busy && busy)) gap_left--;
      end else begin
        in_value <= pending_values.pop_front();
        start    <= 1'b1;
      end
    end
  end

  initial begin
    int           n;
    logic [127:0] tbl;
    logic [63:0]  radix_word;
    bit           rejected;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers come out of reset empty: the core must stay silent.
    queue_value(32'h0000_0000);
    queue_value(32'hFFFF_FFFF);
    queue_value(32'h8000_0000);

    // Decimal; a write past the last register must leave it unchanged.
    load_base(64'd10, DEC_TABLE);
    write_reg(REG_UNUSED, '1);
    @(posedge clk);
    queue_value(32'd0);
    queue_value(32'd1);
    queue_value(32'hFFFF_FFFF);
    queue_value(32'd9);
    queue_value(32'd10);
    queue_value(-32'sd10);
    queue_value(32'h7FFF_FFFF);
    queue_value(32'h8000_0000);
    queue_value(32'd12345);

    // Binary, with garbage above the radix field: the longest runs.
    load_base(64'hFFFF_FFFF_FFFF_FFE2, BIN_TABLE);
    queue_value(32'h8000_0000);
    queue_value(32'h7FFF_FFFF);
    queue_value(32'd0);

    // All sixteen symbols.
    load_base(64'd16, HEX_TABLE);
    queue_value(32'hDEAD_BEEF);
    queue_value(32'h8000_0000);
    queue_value(32'hFFFF_FFFF);

    // Rejected sets: too few symbols, too many, a sign, a zero byte, a repeat.
    load_base(64'd1, HEX_TABLE);
    queue_value(32'h1234_5678);
    load_base(64'd17, HEX_TABLE);
    queue_value(32'h1234_5678);
    load_base('1, HEX_TABLE);
    queue_value(32'h1234_5678);
    load_base(64'd16, spoil_table(HEX_TABLE, 15, SPOIL_PLUS));
    queue_value(32'h8765_4321);
    load_base(64'd3, spoil_table(HEX_TABLE, 1, SPOIL_MINUS));
    queue_value(32'h8765_4321);
    load_base(64'd9, spoil_table(HEX_TABLE, 8, SPOIL_ZERO));
    queue_value(32'h0000_0042);
    load_base(64'd12, spoil_table(HEX_TABLE, 11, SPOIL_DUP));
    queue_value(32'h0000_0042);

    // Random bases and values; every fourth base is broken on purpose.
    // Drop all idling for the last two bases.
    for (int p = 0; p < RANDOM_BASES; p++) begin
      if (p == 0) n = 2;
      else if (p == 1) n = MAX_SYMBOLS;
      else n = $urandom_range(2, MAX_SYMBOLS);
      tbl = random_table(n);
      radix_word = {$urandom, $urandom};
      radix_word[RADIX_W-1:0] = RADIX_W'(n);
      rejected = (p % 4 == 3);
      if (rejected) begin
        case ($urandom_range(0, 5))
          0: radix_word[RADIX_W-1:0] = RADIX_W'($urandom_range(0, 1));
          1: radix_word[RADIX_W-1:0] = RADIX_W'($urandom_range(MAX_SYMBOLS + 1, 31));
          2: tbl = spoil_table(tbl, $urandom_range(1, n - 1), SPOIL_PLUS);
          3: tbl = spoil_table(tbl, $urandom_range(1, n - 1), SPOIL_MINUS);
          4: tbl = spoil_table(tbl, $urandom_range(1, n - 1), SPOIL_ZERO);
          default: tbl = spoil_table(tbl, $urandom_range(1, n - 1), SPOIL_DUP);
        endcase
      end
      load_base(radix_word, tbl);
      if (p == RANDOM_BASES - 2) calm_tail = 1'b1;
      repeat (rejected ? VALUES_PER_NG : VALUES_PER_OK) queue_value(pick_value());
    end

    settle_core();
    $display("covered %0d values over %0d symbol sets, %0d of them under rejected sets",
             values_taken, bases_loaded, values_silent);
    $display("checked %0d characters, %0d mismatches", glyphs_checked, error_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[signed_integer_to_radix_digits_core.f]
src/sird_pkg.sv
src/signed_integer_to_radix_digits_core.sv
tb/sv/tb_signed_integer_to_radix_digits_core.sv
